// ----- rtl/ssa_pkg.sv -----
// shared types and codes for the stack slot allocator
// no dependencies; used by every module of the block
package ssa_pkg;

  // request kinds carried on the slave-side tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes carried on the master-side tuser
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // configuration register indexes (byte address is 4 times the index)
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_TOP  = 2'd1;
  localparam logic [1:0] REG_SIZE = 2'd2;

  localparam int unsigned AddrW  = 4;
  localparam int unsigned AddrW_ = 32;
  localparam int unsigned SizeW  = 21;

  // configuration seen by the datapath
  typedef struct packed {
    logic [AddrW_-1:0] region_low;
    logic [SizeW-1:0]  stack_bytes;
    logic              top_wr;    // region_top written this cycle, re-init state
    logic [AddrW_-1:0] top_val;   // value being written to region_top
  } ssa_cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } ssa_state_e;

endpackage

// ----- rtl/ssa_cfg.sv -----
// configuration registers behind a simple apb-style port
// depends on ssa_pkg for register indexes and the config struct
module ssa_cfg import ssa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ssa_cfg_t         cfg_o
);

  logic [31:0]      low_q, low_d;
  logic [31:0]      top_q, top_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register write decode
  always_comb begin
    low_d  = low_q;
    top_d  = top_q;
    size_d = size_q;
    if (wr_en) begin
      case (reg_idx)
        REG_LOW:  low_d  = pwdata;
        REG_TOP:  top_d  = pwdata;
        REG_SIZE: size_d = pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      top_q  <= '0;
      size_q <= SizeW'(4096);
    end else begin
      low_q  <= low_d;
      top_q  <= top_d;
      size_q <= size_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_LOW:  prdata = low_q;
      REG_TOP:  prdata = top_q;
      REG_SIZE: prdata = {{(32-SizeW){1'b0}}, size_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.region_low  = low_q;
  assign cfg_o.stack_bytes = size_q;
  assign cfg_o.top_wr      = wr_en && (reg_idx == REG_TOP);
  assign cfg_o.top_val     = pwdata;

endmodule

// ----- rtl/ssa_free_list.sv -----
// lifo of freed stack tops: one synchronous memory plus a fill count
// depends on ssa_pkg; read data is registered and appears in the cycle after a pop
module ssa_free_list import ssa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           push_i,
  input  logic                           pop_i,
  input  logic [31:0]                    wdata_i,
  output logic [$clog2(SLOT_COUNT+1)-1:0] count_o,
  output logic [31:0]                    rdata_o
);

  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0]     mem_q [SLOT_COUNT];
  logic [31:0]     rdata_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_m1;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;

  assign count_m1 = count_q - CntW'(1);
  assign wr_idx   = count_q[IdxW-1:0];
  assign rd_idx   = count_m1[IdxW-1:0];

  // memory port: write at the fill level, read just below it
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_idx] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  // fill count
  always_comb begin
    if (clear_i) begin
      count_d = '0;
    end else if (push_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i) begin
      count_d = count_m1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stack_slot_allocator_core.sv -----
// Stack slot allocator: hands out downward-growing stack regions of stack_bytes each.
// A free (tuser 1) is pushed onto a LIFO of SLOT_COUNT entries, or answered full when the
// LIFO is full; an allocate (tuser 0) pops that LIFO when it holds entries, passing through
// ST_POP because the list memory has a registered read, and otherwise takes the bump
// pointer, answering out of memory when the new end would fall below zero or below
// region_low. One request is in flight at a time; the result beat sits in an output
// register, so the next request is taken as soon as that register is free or drains.
// Writing region_top resets the bump pointer and empties the list. No clearing pass.
module stack_slot_allocator_core import ssa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request beat
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,   // [31:0] freed_top
  input  logic             s_axis_tuser_i,   // [0] action
  // result beat
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] given_top
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

  ssa_cfg_t        cfg;
  ssa_state_e      state_q, state_d;
  logic [CntW-1:0] count;
  logic [31:0]     list_rdata;
  logic            acc, is_free, list_empty, list_full;
  logic            do_pop, do_push, do_bump, oom;
  logic            s_ready, pop_done, out_load;
  logic [32:0]     diff;
  logic [31:0]     bump_q, bump_d;
  logic            out_vld_q, out_vld_d;
  logic [31:0]     out_top_q, out_top_d;
  logic [1:0]      out_stat_q, out_stat_d;

  ssa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssa_free_list #(.SLOT_COUNT(SLOT_COUNT)) u_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg.top_wr),
    .push_i  (do_push),
    .pop_i   (do_pop),
    .wdata_i (s_axis_tdata_i),
    .count_o (count),
    .rdata_o (list_rdata)
  );

  // request decode
  assign acc        = s_axis_tvalid_i && s_ready;
  assign is_free    = (s_axis_tuser_i == ACT_FREE);
  assign list_empty = (count == '0);
  assign list_full  = (count == CntW'(SLOT_COUNT));
  assign do_pop     = acc && !is_free && !list_empty;
  assign do_push    = acc && is_free && !list_full;

  // bump check: borrow means stack_bytes exceeds the pointer
  assign diff    = {1'b0, bump_q} - {12'b0, cfg.stack_bytes};
  assign oom     = diff[32] || (diff[31:0] < cfg.region_low);
  assign do_bump = acc && !is_free && list_empty && !oom;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (do_pop) state_d = ST_POP;
      ST_POP:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_ready  = 1'b0;
    pop_done = 1'b0;
    case (state_q)
      ST_IDLE: s_ready  = !out_vld_q || m_axis_tready_i;
      ST_POP:  pop_done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // bump pointer
  always_comb begin
    if (cfg.top_wr) begin
      bump_d = cfg.top_val;
    end else if (do_bump) begin
      bump_d = diff[31:0];
    end else begin
      bump_d = bump_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= '0;
    end else begin
      bump_q <= bump_d;
    end
  end

  // result register: direct results on accept, list pops in the following cycle from ST_POP
  assign out_load = (acc && !do_pop) || pop_done;

  always_comb begin
    out_top_d  = out_top_q;
    out_stat_d = out_stat_q;
    if (pop_done) begin
      out_top_d  = list_rdata;
      out_stat_d = STAT_OK;
    end else if (acc) begin
      out_top_d = do_bump ? bump_q : '0;
      if (is_free) begin
        out_stat_d = list_full ? STAT_FULL : STAT_OK;
      end else begin
        out_stat_d = oom ? STAT_OOM : STAT_OK;
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_top_q  <= out_top_d;
    out_stat_q <= out_stat_d;
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_top_q;
  assign m_axis_tuser_o  = out_stat_q;

  // a pop result never lands on a result beat still waiting
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> !out_vld_q)
    else $error("pop result would overwrite a pending beat");

  // no new request while a pop is reading the list
  a_pop_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> !s_axis_tready_o)
    else $error("request accepted during list read");

  // a push grows the list by exactly one entry
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !cfg.top_wr) |=> (count == $past(count) + CntW'(1)))
    else $error("list count did not follow a push");

  // status code is always one of the defined values
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_stat_q == STAT_OK) || (out_stat_q == STAT_OOM) ||
                   (out_stat_q == STAT_FULL)))
    else $error("undefined status on result beat");

endmodule

// ----- bench/stack_slot_allocator_core_test.sv -----
// self-checking bench for stack_slot_allocator_core: directed and random
// allocate/free requests with a built-in allocator predictor and result checker
// depends on ssa_pkg and the stack_slot_allocator_core rtl
module stack_slot_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned POOL_SZ = 32;

  typedef struct packed {
    logic [31:0] given_top;
    logic [1:0]  status;
  } alloc_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [31:0]      s_axis_tdata_i;   // [31:0] freed_top
  logic             s_axis_tuser_i;   // [0] action
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [31:0]      m_axis_tdata_o;   // [31:0] given_top
  logic [1:0]       m_axis_tuser_o;   // [1:0] status
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // allocator mirror: configuration and state
  logic [31:0] cfg_low  = 32'd0;
  logic [20:0] cfg_size = 21'd4096;
  logic [31:0] bump_ptr = 32'd0;
  logic [31:0] list_tops [SLOTS];
  int unsigned list_count = 0;

  alloc_result_t pending_results[$];
  logic [31:0]   handed_tops[$];
  int unsigned   err_count   = 0;
  int unsigned   hold_cycles = 0;
  bit            gap_en      = 1'b1;
  bit            stall_en    = 1'b1;

  stack_slot_allocator_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // next allocator answer for one request, updates the mirror
  function automatic alloc_result_t predict_alloc(input logic act, input logic [31:0] top);
    alloc_result_t res;
    logic [31:0]   new_end;
    res     = '{given_top: 32'd0, status: STAT_OK};
    new_end = bump_ptr - 32'(cfg_size);
    if (act == ACT_ALLOC) begin
      if (list_count > 0) begin
        list_count--;
        res.given_top = list_tops[list_count];
      end else if (32'(cfg_size) > bump_ptr || new_end < cfg_low) begin
        res.status = STAT_OOM;
      end else begin
        res.given_top = bump_ptr;
        bump_ptr      = new_end;
      end
      // remember handed-out tops so frees can return them
      if (res.status == STAT_OK) begin
        handed_tops.push_back(res.given_top);
        if (handed_tops.size() > POOL_SZ) void'(handed_tops.pop_front());
      end
    end else begin
      if (list_count < SLOTS) begin
        list_tops[list_count] = top;
        list_count++;
      end else begin
        res.status = STAT_FULL;
      end
    end
    return res;
  endfunction

  // predict on each request beat, check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing pending: given_top %h status %0d",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o !== want.given_top) begin
          err_count++;
          $display("%0t: given_top mismatch: expected %h actual %h",
                   $time, want.given_top, m_axis_tdata_o);
        end
        if (m_axis_tuser_o !== want.status) begin
          err_count++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, m_axis_tuser_o);
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      pending_results.push_back(predict_alloc(s_axis_tuser_i, s_axis_tdata_i));
  end

  // result side ready: random stalls, plus a long hold on request
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // offer one request beat and wait until it is taken
  task automatic send_req(input logic act, input logic [31:0] top);
    @(negedge clk_i);
    if (gap_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= top;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // stop offering and wait until every pending result is back
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write on an idle block, mirror updated at the write edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LOW:  cfg_low = val;
      REG_TOP: begin
        bump_ptr   = val;
        list_count = 0;
      end
      REG_SIZE: cfg_size = val[20:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // default registers: bump pointer 0 is smaller than the stack size
  task automatic test_reset_defaults();
    send_req(ACT_ALLOC, 32'h0);
  endtask

  // fresh stacks from the bump pointer until the floor is hit
  task automatic test_bump_pointer();
    write_reg(REG_LOW, 32'h0000_1000);
    write_reg(REG_SIZE, 32'h0000_1000);
    write_reg(REG_TOP, 32'h0000_4000);
    repeat (4) send_req(ACT_ALLOC, 32'hFFFF_FFFF);
  endtask

  // lifo reuse, zero and all-ones tops, floor change keeps the list
  task automatic test_free_list();
    send_req(ACT_FREE, 32'h0000_0000);
    send_req(ACT_FREE, 32'hFFFF_FFFF);
    write_reg(REG_LOW, 32'h0000_0000);
    repeat (3) send_req(ACT_ALLOC, 32'h0);
  endtask

  // top write empties the list, then overfill it
  task automatic test_list_full();
    int unsigned i;
    write_reg(REG_TOP, 32'h8000_0000);
    for (i = 0; i <= SLOTS; i++) begin
      if (i[0]) send_req(ACT_FREE, 32'hAAAA_AAAA ^ i);
      else send_req(ACT_FREE, 32'h5555_5555 ^ i);
    end
    send_req(ACT_ALLOC, 32'h0);
  endtask

  // zero size, widest size, top of the address space, bump below zero
  task automatic test_size_extremes();
    write_reg(REG_SIZE, 32'h0);
    write_reg(REG_LOW, 32'hFFFF_FFFF);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    repeat (2) send_req(ACT_ALLOC, 32'h0);
    write_reg(REG_SIZE, 32'h001F_FFFF);
    write_reg(REG_LOW, 32'h0);
    write_reg(REG_TOP, 32'h001F_FFFF);
    repeat (2) send_req(ACT_ALLOC, 32'h0);
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_backpressure();
    int unsigned i;
    write_reg(REG_SIZE, 32'h0000_0100);
    write_reg(REG_TOP, 32'h0001_0000);
    gap_en      = 1'b0;
    hold_cycles = 60;
    for (i = 0; i < 20; i++)
      send_req(i[0] ? ACT_FREE : ACT_ALLOC, $urandom);
    wait_drain();
    gap_en = 1'b1;
  endtask

  // random phases of allocate/free traffic under varied regions
  task automatic test_random_mix();
    int unsigned phase;
    int unsigned n;
    int unsigned free_pct;
    int unsigned depth;
    logic [31:0] sz;
    logic [31:0] top;
    logic [31:0] low;
    logic [63:0] span;
    logic        act;
    logic [31:0] ftop;
    for (phase = 0; phase < 10; phase++) begin
      if (phase >= 8) begin
        gap_en   = 1'b0;
        stall_en = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       sz = 32'h0;
        1:       sz = 32'h0010_0000;
        2:       sz = 32'h001F_FFFF;
        default: sz = $urandom_range(1, 4096);
      endcase
      // small tops reach the below-zero case
      if ($urandom_range(0, 3) == 0) top = $urandom_range(0, 3 * sz);
      else top = $urandom;
      depth = $urandom_range(0, 40);
      span  = 64'(depth) * 64'(sz);
      low   = (span > 64'(top)) ? 32'h0 : top - span[31:0];
      write_reg(REG_SIZE, sz);
      write_reg(REG_LOW, low);
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(REG_TOP, top);
      case ($urandom_range(0, 3))
        0:       free_pct = 25;
        1:       free_pct = 50;
        2:       free_pct = 60;
        default: free_pct = 75;
      endcase
      for (n = 0; n < 100; n++) begin
        act = ($urandom_range(0, 99) < free_pct) ? ACT_FREE : ACT_ALLOC;
        if (handed_tops.size() != 0 && $urandom_range(0, 1) == 0)
          ftop = handed_tops.pop_back();
        else
          ftop = $urandom;
        send_req(act, ftop);
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 32'h0;
    s_axis_tuser_i  = ACT_ALLOC;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = 32'h0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_bump_pointer();
    test_free_list();
    test_list_full();
    test_size_extremes();
    test_backpressure();
    test_random_mix();

    wait_drain();
    repeat (20) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      err_count++;
      $display("%0t: result never arrived: expected given_top %h status %0d",
               $time, pending_results[0].given_top, pending_results[0].status);
      void'(pending_results.pop_front());
    end
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
